// ===== rtl/tlbpt_pkg.sv =====
// Shared types and constants for the TLB and page-table translator.
`default_nettype none
package tlbpt_pkg;

    localparam int VA_W      = 16;
    localparam int PA_W      = 15;
    localparam int PAGE_BITS = 8;
    localparam int PN_W      = VA_W - PAGE_BITS;
    localparam int NUM_PAGES = 1 << PN_W;

    typedef logic [VA_W-1:0]      t_vaddr;
    typedef logic [PA_W-1:0]      t_paddr;
    typedef logic [PN_W-1:0]      t_page;
    typedef logic [PAGE_BITS-1:0] t_offset;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/tlbpt_if.sv =====
// Valid/ready channel interfaces for address items and translation results.
`default_nettype none
interface tlbpt_in_if;
    import tlbpt_pkg::*;

    logic   valid;
    logic   ready;
    t_vaddr virt_addr;

    modport source (output valid, output virt_addr, input ready);
    modport sink (input valid, input virt_addr, output ready);
endinterface

interface tlbpt_out_if;
    import tlbpt_pkg::*;

    logic   valid;
    logic   ready;
    t_paddr phys_addr;
    logic   tlb_hit;
    logic   page_fault;

    modport source (output valid, output phys_addr, output tlb_hit, output page_fault,
                    input ready);
    modport sink (input valid, input phys_addr, input tlb_hit, input page_fault,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/tlbpt_ctrl.sv =====
// Controller state machine: accept, look up, commit.
`default_nettype none
module tlbpt_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  tlbpt_pkg::t_dp_status   i_status,
    output tlbpt_pkg::t_ctrl_cmd    o_cmd
);
    import tlbpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_RES;
            end
            S_RES: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tlbpt_dpath.sv =====
// Datapath: TLB, page-table valid bits, frame and reverse-map memories, result register.
`default_nettype none
module tlbpt_dpath #(
    parameter int TLB_ENTRIES = 16,
    parameter int NUM_FRAMES  = 128
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  tlbpt_pkg::t_ctrl_cmd    i_cmd,
    output tlbpt_pkg::t_dp_status   o_status,
    input  tlbpt_pkg::t_vaddr       i_virt_addr,
    input  wire                     i_out_ready,
    output logic                    o_out_valid,
    output tlbpt_pkg::t_paddr       o_phys_addr,
    output logic                    o_tlb_hit,
    output logic                    o_page_fault
);
    import tlbpt_pkg::*;

    localparam int TW = $clog2(TLB_ENTRIES);
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = FW + PAGE_BITS;
    localparam logic [TW-1:0] TLB_LAST   = TW'(TLB_ENTRIES - 1);
    localparam logic [FW-1:0] FRAME_LAST = FW'(NUM_FRAMES - 1);

    // Captured item
    t_vaddr r_va;

    // TLB
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    t_page                  r_tlb_page  [TLB_ENTRIES];
    logic [FW-1:0]          r_tlb_frame [TLB_ENTRIES];
    logic [TW-1:0]          r_tlb_next;

    // Page table and frame allocation
    logic [NUM_PAGES-1:0]   r_pt_valid;
    logic [FW-1:0]          mem_pt_frame [NUM_PAGES];
    t_page                  mem_rmap     [NUM_FRAMES];
    logic [FW-1:0]          r_frame_next;
    logic                   r_wrapped;

    // Lookup results
    logic                   r_hit;
    logic [FW-1:0]          r_hit_frame;
    logic                   r_pt_hit;
    logic [FW-1:0]          r_pt_rd;
    t_page                  r_rmap_rd;

    // Output register
    logic                   r_out_valid;
    t_paddr                 r_out_pa;
    logic                   r_out_hit;
    logic                   r_out_fault;

    t_page                  pg;
    t_offset                off;
    logic                   n_hit;
    logic [FW-1:0]          n_hit_frame;
    logic                   fault;
    logic                   refill;
    logic [FW-1:0]          frame_sel;
    logic [CW-1:0]          pa_full;

    assign pg  = r_va[VA_W-1:PAGE_BITS];
    assign off = r_va[PAGE_BITS-1:0];

    // Lowest matching TLB entry wins
    always_comb begin
        n_hit       = 1'b0;
        n_hit_frame = '0;
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            if (!n_hit && r_tlb_valid[k] && (r_tlb_page[k] == pg)) begin
                n_hit       = 1'b1;
                n_hit_frame = r_tlb_frame[k];
            end
        end
    end

    assign fault     = !r_hit && !r_pt_hit;
    assign refill    = !r_hit && r_pt_hit;
    assign frame_sel = r_hit ? r_hit_frame : (r_pt_hit ? r_pt_rd : r_frame_next);
    assign pa_full   = {frame_sel, off};

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_va <= i_virt_addr;
        end
        if (i_cmd.lookup) begin
            r_hit       <= n_hit;
            r_hit_frame <= n_hit_frame;
            r_pt_hit    <= r_pt_valid[pg];
            r_pt_rd     <= mem_pt_frame[pg];
            r_rmap_rd   <= mem_rmap[r_frame_next];
        end
        if (i_cmd.commit) begin
            r_out_pa    <= PA_W'(pa_full);
            r_out_hit   <= r_hit;
            r_out_fault <= fault;
        end
    end

    // Memories: frame per page and page per frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && fault) begin
            mem_pt_frame[pg]       <= r_frame_next;
            mem_rmap[r_frame_next] <= pg;
        end
    end

    // TLB payload: refill one slot, or retarget entries that hold the taken frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && refill) begin
            r_tlb_page[r_tlb_next]  <= pg;
            r_tlb_frame[r_tlb_next] <= r_pt_rd;
        end
        if (i_cmd.commit && fault) begin
            for (int k = 0; k < TLB_ENTRIES; k++) begin
                if (r_tlb_valid[k] && (r_tlb_frame[k] == r_frame_next)) begin
                    r_tlb_page[k] <= pg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid  <= '0;
            r_tlb_next   <= '0;
            r_pt_valid   <= '0;
            r_frame_next <= '0;
            r_wrapped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit && refill) begin
                r_tlb_valid[r_tlb_next] <= 1'b1;
                r_tlb_next <= (r_tlb_next == TLB_LAST) ? '0 : r_tlb_next + 1'b1;
            end
            if (i_cmd.commit && fault) begin
                // once wrapped, the taken frame still backs exactly one valid page
                if (r_wrapped) begin
                    r_pt_valid[r_rmap_rd] <= 1'b0;
                end
                r_pt_valid[pg] <= 1'b1;
                if (r_frame_next == FRAME_LAST) begin
                    r_frame_next <= '0;
                    r_wrapped    <= 1'b1;
                end else begin
                    r_frame_next <= r_frame_next + 1'b1;
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_phys_addr  = r_out_pa;
    assign o_tlb_hit    = r_out_hit;
    assign o_page_fault = r_out_fault;

endmodule
`default_nettype wire

// ===== rtl/tlb_page_table_translator_core.sv =====
// Top level of the virtual-to-physical translator with FIFO-refilled TLB and page table.
//
// Each item is a 16-bit virtual address (page in bits 15:8, offset in 7:0)
// and yields one result: the 15-bit physical address and flags for a TLB hit
// and for a page fault. An item passes three steps from acceptance to a
// registered result: capture, lookup (parallel TLB compare plus registered
// reads of the page-frame and reverse-map memories), and commit. The next item
// is accepted in the cycle after commit, so the block takes no new item until
// the last one has committed; the result register lets the next
// item be accepted while the previous result waits. A reverse map from frame
// to page lets a fault drop the old mapping of the reused frame in one step.
// All valid bits clear at reset; no clearing pass is needed.
`default_nettype none
module tlb_page_table_translator_core #(
    parameter int TLB_ENTRIES = 16,
    parameter int NUM_FRAMES  = 128
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tlbpt_in_if.sink      i_in,
    tlbpt_out_if.source   o_out
);
    import tlbpt_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    tlbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tlbpt_dpath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .NUM_FRAMES  (NUM_FRAMES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_virt_addr  (i_in.virt_addr),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_phys_addr  (o_out.phys_addr),
        .o_tlb_hit    (o_out.tlb_hit),
        .o_page_fault (o_out.page_fault)
    );

endmodule
`default_nettype wire

// ===== rtl/tlbpt_checker.sv =====
// Port-level assertions for the translator and the bind that attaches them.
`default_nettype none
module tlbpt_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  tlbpt_pkg::t_paddr   i_phys_addr,
    input  wire                 i_tlb_hit,
    input  wire                 i_page_fault
);
    import tlbpt_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_phys_addr) && $stable(i_tlb_hit)
             && $stable(i_page_fault)))
        else $error("result changed while stalled");

    // one item at a time: no accept right after an accept
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !in_acc)
        else $error("item accepted during lookup");

    // a TLB hit never faults
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_tlb_hit && i_page_fault))
        else $error("hit and fault both set");

    // a result cannot appear in the cycle after acceptance
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result too early");

endmodule

bind tlb_page_table_translator_core tlbpt_checker u_tlbpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_phys_addr  (o_out.phys_addr),
    .i_tlb_hit    (o_out.tlb_hit),
    .i_page_fault (o_out.page_fault)
);
`default_nettype wire
